// ===== rtl/mmsa_pkg.sv =====
package mmsa_pkg;

  // lane count and fixed point layout
  localparam int LANES          = 4;
  localparam int TRIG_FRAC_BITS = 10;
  localparam int ACC_WIDTH      = 40;

  // field widths
  localparam int PT_W   = 14;
  localparam int PHI_W  = 11;
  localparam int OUT_W  = 40;

  // angle geometry, 720 units = pi
  localparam int HALF    = 720;
  localparam int QUARTER = 360;
  localparam int IDX_W   = $clog2(QUARTER + 1);

  // table magnitude reaches 2^TRIG_FRAC_BITS at the quarter points
  localparam int TRIG_W    = TRIG_FRAC_BITS + 1;
  localparam int PROD_W    = PT_W + TRIG_W;
  localparam int CONTRIB_W = PROD_W + 1;
  localparam int SUM_W     = CONTRIB_W + $clog2(LANES);

  typedef logic [TRIG_W-1:0] trig_tab_t [0:QUARTER];

  // frame tokens that travel with a slice
  typedef struct packed {
    logic start;
    logic last;
    logic orbit;
  } mmsa_flags_t;

  // stage loads driven into each lane
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } mmsa_lane_ctl_t;

  // stage loads driven into the merge stage
  typedef struct packed {
    logic s3_load;
    logic s4_load;
    logic acc_en;
  } mmsa_merge_ctl_t;

  // table generation in Q60, evaluated at elaboration only
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] STEP_Q = PI_Q60 / 64'd720;
  localparam int          QBITS  = 60;
  localparam int          TERMS  = 16;

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[QBITS+63:QBITS];
  endfunction

  // truncating quotient by shift and subtract
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [TRIG_W-1:0] trig_value(int i, logic want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] den;
    logic [63:0] rnd;
    x    = STEP_Q * 64'(i);
    x2   = mulq(x, x);
    term = want_cos ? (64'd1 << QBITS) : x;
    acc  = term;
    for (int k = 1; k <= TERMS; k++) begin
      den  = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = udiv(mulq(term, x2), den);
      if ((k % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    rnd = (acc + (64'd1 << (QBITS - 1 - TRIG_FRAC_BITS))) >> (QBITS - TRIG_FRAC_BITS);
    return rnd[TRIG_W-1:0];
  endfunction

  function automatic trig_tab_t build_tab(logic want_cos);
    trig_tab_t t;
    for (int i = 0; i <= QUARTER; i++) begin
      t[i] = trig_value(i, want_cos);
    end
    return t;
  endfunction

  localparam trig_tab_t COS_TAB = build_tab(1'b1);
  localparam trig_tab_t SIN_TAB = build_tab(1'b0);

endpackage

// ===== rtl/mmsa_lane.sv =====
module mmsa_lane (
  input  logic                                     clk,
  input  mmsa_pkg::mmsa_lane_ctl_t                 ctl,
  input  logic        [mmsa_pkg::PT_W-1:0]         pt,
  input  logic signed [mmsa_pkg::PHI_W-1:0]        phi,
  output logic signed [mmsa_pkg::CONTRIB_W-1:0]    contrib_x,
  output logic signed [mmsa_pkg::CONTRIB_W-1:0]    contrib_y
);

  localparam logic signed [mmsa_pkg::PHI_W:0] PHI_HALF =
    (mmsa_pkg::PHI_W+1)'(mmsa_pkg::HALF);
  localparam logic signed [mmsa_pkg::PHI_W:0] PHI_QUARTER =
    (mmsa_pkg::PHI_W+1)'(mmsa_pkg::QUARTER);

  logic signed [mmsa_pkg::PHI_W:0]     phi_w;
  logic signed [mmsa_pkg::PHI_W:0]     phi_c;
  logic signed [mmsa_pkg::PHI_W:0]     idx_w;
  logic        [mmsa_pkg::IDX_W-1:0]   idx;
  logic                                x_pos;
  logic                                y_pos;

  logic        [mmsa_pkg::PT_W-1:0]    pt_r;
  logic        [mmsa_pkg::TRIG_W-1:0]  cos_r;
  logic        [mmsa_pkg::TRIG_W-1:0]  sin_r;
  logic                                x_pos_r;
  logic                                y_pos_r;

  logic        [mmsa_pkg::PROD_W-1:0]  prod_x;
  logic        [mmsa_pkg::PROD_W-1:0]  prod_y;
  logic signed [mmsa_pkg::CONTRIB_W-1:0] contrib_x_nxt;
  logic signed [mmsa_pkg::CONTRIB_W-1:0] contrib_y_nxt;
  logic signed [mmsa_pkg::CONTRIB_W-1:0] contrib_x_r;
  logic signed [mmsa_pkg::CONTRIB_W-1:0] contrib_y_r;

  // clamp, fold into the first quarter wave
  always_comb begin
    phi_w = (mmsa_pkg::PHI_W+1)'(phi);
    if (phi_w < -PHI_HALF) begin
      phi_c = -PHI_HALF;
    end else if (phi_w > PHI_HALF) begin
      phi_c = PHI_HALF;
    end else begin
      phi_c = phi_w;
    end
    if (phi_c <= -PHI_QUARTER) begin
      idx_w = phi_c + PHI_HALF;
    end else if (phi_c < 0) begin
      idx_w = -phi_c;
    end else if (phi_c <= PHI_QUARTER) begin
      idx_w = phi_c;
    end else begin
      idx_w = PHI_HALF - phi_c;
    end
    idx   = idx_w[mmsa_pkg::IDX_W-1:0];
    // negated projection: positive when the true component is negative
    x_pos = (phi_c < -PHI_QUARTER) || (phi_c > PHI_QUARTER);
    y_pos = (phi_c < 0);
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      pt_r    <= pt;
      cos_r   <= mmsa_pkg::COS_TAB[idx];
      sin_r   <= mmsa_pkg::SIN_TAB[idx];
      x_pos_r <= x_pos;
      y_pos_r <= y_pos;
    end
  end

  always_comb begin
    prod_x        = mmsa_pkg::PROD_W'(pt_r) * mmsa_pkg::PROD_W'(cos_r);
    prod_y        = mmsa_pkg::PROD_W'(pt_r) * mmsa_pkg::PROD_W'(sin_r);
    contrib_x_nxt = x_pos_r ? signed'({1'b0, prod_x}) : -signed'({1'b0, prod_x});
    contrib_y_nxt = y_pos_r ? signed'({1'b0, prod_y}) : -signed'({1'b0, prod_y});
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      contrib_x_r <= contrib_x_nxt;
      contrib_y_r <= contrib_y_nxt;
    end
  end

  assign contrib_x = contrib_x_r;
  assign contrib_y = contrib_y_r;

endmodule

// ===== rtl/mmsa_merge.sv =====
module mmsa_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mmsa_pkg::mmsa_merge_ctl_t                ctl,
  input  mmsa_pkg::mmsa_flags_t                    flags,
  input  logic signed [mmsa_pkg::CONTRIB_W-1:0]    contrib_x [mmsa_pkg::LANES],
  input  logic signed [mmsa_pkg::CONTRIB_W-1:0]    contrib_y [mmsa_pkg::LANES],
  output logic signed [mmsa_pkg::OUT_W-1:0]        met_x,
  output logic signed [mmsa_pkg::OUT_W-1:0]        met_y,
  output mmsa_pkg::mmsa_flags_t                    tok
);

  logic signed [mmsa_pkg::SUM_W-1:0]     slice_x_nxt;
  logic signed [mmsa_pkg::SUM_W-1:0]     slice_y_nxt;
  logic signed [mmsa_pkg::SUM_W-1:0]     slice_x_r;
  logic signed [mmsa_pkg::SUM_W-1:0]     slice_y_r;
  mmsa_pkg::mmsa_flags_t                 flags3_r;
  mmsa_pkg::mmsa_flags_t                 tok_nxt;
  mmsa_pkg::mmsa_flags_t                 tok_r;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] acc_x_r;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] acc_y_r;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] acc_x_nxt;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] acc_y_nxt;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] base_x;
  logic signed [mmsa_pkg::ACC_WIDTH-1:0] base_y;

  // lane sum
  always_comb begin
    slice_x_nxt = '0;
    slice_y_nxt = '0;
    for (int i = 0; i < mmsa_pkg::LANES; i++) begin
      slice_x_nxt = slice_x_nxt + mmsa_pkg::SUM_W'(contrib_x[i]);
      slice_y_nxt = slice_y_nxt + mmsa_pkg::SUM_W'(contrib_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      slice_x_r <= slice_x_nxt;
      slice_y_r <= slice_y_nxt;
      flags3_r  <= flags;
    end
  end

  // start clears before the slice goes in; sums wrap
  always_comb begin
    base_x    = flags3_r.start ? '0 : acc_x_r;
    base_y    = flags3_r.start ? '0 : acc_y_r;
    acc_x_nxt = base_x + mmsa_pkg::ACC_WIDTH'(slice_x_r);
    acc_y_nxt = base_y + mmsa_pkg::ACC_WIDTH'(slice_y_r);
    tok_nxt.start = flags3_r.start;
    tok_nxt.last  = !flags3_r.start && flags3_r.last;
    tok_nxt.orbit = !flags3_r.start && flags3_r.last && flags3_r.orbit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (ctl.acc_en) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s4_load) begin
      tok_r <= tok_nxt;
    end
  end

  assign met_x = mmsa_pkg::OUT_W'(acc_x_r);
  assign met_y = mmsa_pkg::OUT_W'(acc_y_r);
  assign tok   = tok_r;

endmodule

// ===== rtl/missing_momentum_slice_accumulator_core.sv =====
// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     in_pt_0..3, in_phi_0..3, in_frame_start,
//                                              in_frame_last, in_orbit_start
// out_      output     out_valid / out_ready   out_met_x, out_met_y, out_out_start,
//                                              out_out_last, out_out_orbit_start,
//                                              out_out_valid
//
// one transaction per cycle sustained while out_ready is held high
// stages: table lookup, lane multiply, lane sum, accumulate (accumulator is the
// output register)
// rst_n is synchronous; it empties the pipeline and zeroes both accumulators
// each stage advances when it is empty or the stage after it moves, so a stalled
// result only blocks input once all four stages hold a transaction
module missing_momentum_slice_accumulator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [mmsa_pkg::PT_W-1:0]      in_pt_0,
  input  logic        [mmsa_pkg::PT_W-1:0]      in_pt_1,
  input  logic        [mmsa_pkg::PT_W-1:0]      in_pt_2,
  input  logic        [mmsa_pkg::PT_W-1:0]      in_pt_3,
  input  logic signed [mmsa_pkg::PHI_W-1:0]     in_phi_0,
  input  logic signed [mmsa_pkg::PHI_W-1:0]     in_phi_1,
  input  logic signed [mmsa_pkg::PHI_W-1:0]     in_phi_2,
  input  logic signed [mmsa_pkg::PHI_W-1:0]     in_phi_3,
  input  logic                                  in_frame_start,
  input  logic                                  in_frame_last,
  input  logic                                  in_orbit_start,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mmsa_pkg::OUT_W-1:0]     out_met_x,
  output logic signed [mmsa_pkg::OUT_W-1:0]     out_met_y,
  output logic                                  out_out_start,
  output logic                                  out_out_last,
  output logic                                  out_out_orbit_start,
  output logic                                  out_out_valid
);

  // per lane input vectors
  logic        [mmsa_pkg::PT_W-1:0]      pt_lane  [mmsa_pkg::LANES];
  logic signed [mmsa_pkg::PHI_W-1:0]     phi_lane [mmsa_pkg::LANES];
  logic signed [mmsa_pkg::CONTRIB_W-1:0] cx_lane  [mmsa_pkg::LANES];
  logic signed [mmsa_pkg::CONTRIB_W-1:0] cy_lane  [mmsa_pkg::LANES];

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  mmsa_pkg::mmsa_flags_t     flags_in;
  mmsa_pkg::mmsa_flags_t     flags1_r;
  mmsa_pkg::mmsa_flags_t     flags2_r;
  mmsa_pkg::mmsa_flags_t     tok;
  mmsa_pkg::mmsa_lane_ctl_t  lane_ctl;
  mmsa_pkg::mmsa_merge_ctl_t merge_ctl;

  assign pt_lane[0]  = in_pt_0;
  assign pt_lane[1]  = in_pt_1;
  assign pt_lane[2]  = in_pt_2;
  assign pt_lane[3]  = in_pt_3;
  assign phi_lane[0] = in_phi_0;
  assign phi_lane[1] = in_phi_1;
  assign phi_lane[2] = in_phi_2;
  assign phi_lane[3] = in_phi_3;

  assign flags_in.start = in_frame_start;
  assign flags_in.last  = in_frame_last;
  assign flags_in.orbit = in_orbit_start;

  // backpressure ripples from the output register toward the input
  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;
  assign v4_nxt = rdy4 ? v3_r     : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // frame flags ride alongside the lane payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      flags1_r <= flags_in;
    end
    if (rdy2) begin
      flags2_r <= flags1_r;
    end
  end

  assign lane_ctl.s1_load  = rdy1;
  assign lane_ctl.s2_load  = rdy2;
  assign merge_ctl.s3_load = rdy3;
  assign merge_ctl.s4_load = rdy4;
  // the accumulator only moves for a real transaction
  assign merge_ctl.acc_en  = rdy4 && v3_r;

  for (genvar g = 0; g < mmsa_pkg::LANES; g++) begin : g_lane
    mmsa_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .pt        (pt_lane[g]),
      .phi       (phi_lane[g]),
      .contrib_x (cx_lane[g]),
      .contrib_y (cy_lane[g])
    );
  end

  mmsa_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .flags     (flags2_r),
    .contrib_x (cx_lane),
    .contrib_y (cy_lane),
    .met_x     (out_met_x),
    .met_y     (out_met_y),
    .tok       (tok)
  );

  assign out_valid           = v4_r;
  assign out_out_start       = tok.start;
  assign out_out_last        = tok.last;
  assign out_out_orbit_start = tok.orbit;
  // data-valid token mirrors the last token
  assign out_out_valid       = tok.last;

endmodule

// ===== rtl/mmsa_checker.sv =====
module mmsa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mmsa_pkg::OUT_W-1:0] out_met_x,
  input logic                              out_out_start,
  input logic                              out_out_last,
  input logic                              out_out_orbit_start,
  input logic                              out_out_valid
);

  a_valid_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_valid == out_out_last))
    else $error("data-valid token differs from last token");

  a_start_excludes_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_start) |-> !out_out_last)
    else $error("start and last tokens together");

  a_orbit_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_last) |-> !out_out_orbit_start)
    else $error("orbit token without last token");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_met_x)))
    else $error("stalled result changed");

endmodule

bind missing_momentum_slice_accumulator_core mmsa_checker u_mmsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_met_x           (out_met_x),
  .out_out_start       (out_out_start),
  .out_out_last        (out_out_last),
  .out_out_orbit_start (out_out_orbit_start),
  .out_out_valid       (out_out_valid)
);
